/* hw/rtl/itcs_pkg.sv */
// ----------------------------------------------------------------------------
// itcs_pkg: shared types and constants for the IPv4/TCP/UDP checksum block
// Mode codes, header size limits, protocol numbers, state and result structs and the
// end-around-carry adder.
// ----------------------------------------------------------------------------
package itcs_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_IP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TCP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UDP   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_TCP;

	localparam logic [WORD_W-1:0] IP_HDR_BYTES  = 16'd20;
	localparam logic [WORD_W-1:0] TCP_MIN_BYTES = 16'd40;
	localparam logic [WORD_W-1:0] UDP_MIN_BYTES = 16'd28;
	localparam logic [WORD_W-1:0] PROTO_TCP     = 16'd6;
	localparam logic [WORD_W-1:0] PROTO_UDP     = 16'd17;
	localparam logic [WORD_W-1:0] LEN_OFFSET    = 16'd2;
	localparam logic [WORD_W-1:0] ADDR_OFFSET   = 16'd12;
	localparam logic [WORD_W-1:0] WORD_BYTES    = 16'd2;
	localparam logic [WORD_W-1:0] HIGH_BYTE     = 16'hFF00;

	typedef struct packed {
		logic [WORD_W-1:0] sum;
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] len;
		logic              active;
	} csum_state_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] sum;
		logic              err;
	} csum_result_t;

	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage

/* hw/rtl/ipv4_tcp_udp_checksum.sv */
// ----------------------------------------------------------------------------
// ipv4_tcp_udp_checksum: streaming IPv4 / TCP / UDP ones' complement sum
// Stages: input register, then result register, between item accept and result.
// Throughput: one 16-bit word per cycle when not stalled; the end-around-carry add
// and length checks sit between the input register and the result register.
// Reset: clears the packet state and the pipeline valids; mode resets to TCP.
// ----------------------------------------------------------------------------
module ipv4_tcp_udp_checksum (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [itcs_pkg::MODE_W-1:0] checksum_mode,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [itcs_pkg::WORD_W-1:0] data_word,
	input  logic                        first_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [itcs_pkg::WORD_W-1:0] checksum_sum,
	output logic                        length_error
);
	import itcs_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              valid_s1;
	logic [WORD_W-1:0] data_s1;
	logic              first_s1;
	csum_state_t       state_q;
	csum_state_t       state_nxt;
	csum_result_t      res;
	logic              out_free;
	logic              step_ok;
	logic              in_acc;

	itcs_step u_step (
		.cur      (state_q),
		.word     (data_s1),
		.first    (first_s1),
		.mode_raw (mode_q),
		.nxt      (state_nxt),
		.res      (res)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;
	assign step_ok   = valid_s1 && (!res.valid || out_free);
	assign in_stall  = valid_s1 && !step_ok;
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= checksum_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (step_ok) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= data_word;
			first_s1 <= first_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step_ok) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step_ok && res.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_ok && res.valid) begin
			checksum_sum <= res.sum;
			length_error <= res.err;
		end
	end

	a_err_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> checksum_sum == '0)
		else $error("length error result with nonzero sum");

	a_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step_ok && res.valid |=> !state_q.active)
		else $error("packet still open after its result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !(step_ok && res.valid))
		else $error("pending result overwritten");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule

/* hw/rtl/itcs_step.sv */
// ----------------------------------------------------------------------------
// itcs_step: per-word checksum update
// Takes the packet state and one word, gives the next state and the result
// for that word, if any.
// ----------------------------------------------------------------------------
module itcs_step (
	input  itcs_pkg::csum_state_t       cur,
	input  logic [itcs_pkg::WORD_W-1:0] word,
	input  logic                        first,
	input  logic [itcs_pkg::MODE_W-1:0] mode_raw,
	output itcs_pkg::csum_state_t       nxt,
	output itcs_pkg::csum_result_t      res
);
	import itcs_pkg::*;

	always_comb begin
		logic [MODE_W-1:0] mode;
		csum_state_t       s;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] sum;
		logic [WORD_W-1:0] minlen;
		logic [WORD_W-1:0] w;
		logic              short_len;

		mode = (mode_raw == MODE_ALIAS) ? MODE_IP : mode_raw;
		s = cur;
		if (first) begin
			s.sum    = '0;
			s.pos    = '0;
			s.len    = '0;
			s.active = 1'b1;
		end
		nxt       = s;
		res       = '0;
		p         = s.pos;
		len       = s.len;
		sum       = s.sum;
		short_len = 1'b0;
		w         = word;
		minlen    = (mode == MODE_TCP) ? TCP_MIN_BYTES :
			((mode == MODE_UDP) ? UDP_MIN_BYTES : IP_HDR_BYTES);

		if (s.active) begin
			nxt.pos = p + WORD_BYTES;
			if (p == LEN_OFFSET) begin
				len     = word;
				nxt.len = word;
				if (word < minlen) begin
					short_len  = 1'b1;
					nxt.active = 1'b0;
					nxt.sum    = '0;
					res.valid  = 1'b1;
					res.err    = 1'b1;
				end else if (mode != MODE_IP) begin
					sum = oc_add(sum, (mode == MODE_TCP) ? PROTO_TCP : PROTO_UDP);
					sum = oc_add(sum, word - IP_HDR_BYTES);
				end
			end

			if (!short_len) begin
				if (mode == MODE_IP) begin
					if (p < IP_HDR_BYTES)
						sum = oc_add(sum, word);
					if (p == IP_HDR_BYTES - WORD_BYTES) begin
						nxt.active = 1'b0;
						res.valid  = 1'b1;
						res.sum    = sum;
					end
				end else begin
					if (p >= ADDR_OFFSET && p < IP_HDR_BYTES) begin
						sum = oc_add(sum, word);
					end else if (p >= IP_HDR_BYTES && p < len) begin
						// odd last byte: pad low byte with zero
						if ({1'b0, p} + 17'd1 == {1'b0, len})
							w = word & HIGH_BYTE;
						sum = oc_add(sum, w);
					end
					if (p >= IP_HDR_BYTES && ({1'b0, p} + {1'b0, WORD_BYTES}) >= {1'b0, len})
					begin
						nxt.active = 1'b0;
						res.valid  = 1'b1;
						res.sum    = sum;
					end
				end
				nxt.sum = sum;
			end
		end
	end

endmodule
